// ===== src/arpc_pkg.sv =====
package arpc_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ENTRY_W = 80;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 48;

   localparam logic [15:0] HW_ETHERNET = 16'h0001;
   localparam logic [15:0] PROTO_IPV4 = 16'h0800;
   localparam logic [15:0] OP_REQUEST = 16'h0001;

   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_IP = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_MAC = 1'b1;

   localparam logic [2:0] ST_REPLY = 3'd0;
   localparam logic [2:0] ST_BAD_HW = 3'd1;
   localparam logic [2:0] ST_BAD_PROTO = 3'd2;
   localparam logic [2:0] ST_NOT_FOR_US = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL = 3'd4;
   localparam logic [2:0] ST_NOT_REQUEST = 3'd5;

   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_MERGED = 2'd1;
   localparam logic [1:0] ACT_INSERTED = 2'd2;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   function automatic logic [3:0] idx_to_out(input logic [IDX_W-1:0] idx);
      logic [IDX_W+3:0] t;
      t = {4'b0000, idx};
      return t[3:0];
   endfunction

endpackage

// ===== src/arpc_if.sv =====
interface arpc_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] hw_type;
   logic [15:0] proto_type;
   logic [15:0] arp_operation;
   logic [47:0] sender_mac;
   logic [31:0] sender_ip;
   logic [31:0] target_ip;

   modport source (output valid, hw_type, proto_type, arp_operation, sender_mac,
                   sender_ip, target_ip, input ready);
   modport sink (input valid, hw_type, proto_type, arp_operation, sender_mac,
                 sender_ip, target_ip, output ready);
endinterface

interface arpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  table_action;
   logic [3:0]  entry_index;
   logic        reply_valid;
   logic [47:0] reply_target_mac;
   logic [31:0] reply_target_ip;

   modport source (output valid, status, table_action, entry_index, reply_valid,
                   reply_target_mac, reply_target_ip, input ready);
   modport sink (input valid, status, table_action, entry_index, reply_valid,
                 reply_target_mac, reply_target_ip, output ready);
endinterface

// ===== src/arpc_ram.sv =====
module arpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                             wdata,
   input  logic                                         re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                             rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== src/arp_responder_with_cache.sv =====
// ARP receive handler with a sender address cache. Each request transaction carries the
// decoded fields of one received ARP packet and yields exactly one response transaction.
// The cache fills from entry 0 upwards and is never freed, so the valid entries are those
// below a fill count that reset clears; there is no clearing pass. A packet with a bad
// hardware or protocol type is answered without reading the cache. Otherwise the valid
// entries are read one per cycle from the cache memory (registered read) and compared
// with the sender IP, until the first match or, on a miss, until all entries below the
// fill count have been read. One packet is processed at a time; a new packet is accepted
// as soon as the previous one has moved into the response register. local_ip and
// local_mac are written through the csr port; the user must write them only while the
// block is idle, which the block itself does not enforce.
module arp_responder_with_cache (
   input  logic                              clock,
   input  logic                              reset,
   arpc_req_if.sink                          req_chan,
   arpc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [arpc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   arpc_pkg::state_type state_ff, state_in;

   logic [31:0] local_ip_ff, local_ip_in;
   logic [47:0] local_mac_ff, local_mac_in;

   logic [15:0] hw_ff, hw_in;
   logic [15:0] proto_ff, proto_in;
   logic [15:0] op_ff, op_in;
   logic [47:0] smac_ff, smac_in;
   logic [31:0] sip_ff, sip_in;
   logic [31:0] tip_ff, tip_in;

   logic [arpc_pkg::CNT_W-1:0] count_ff, count_in;
   logic [arpc_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic [arpc_pkg::IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic                       pend_ff, pend_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff, status_in;
   logic [1:0]  action_ff, action_in;
   logic [3:0]  index_ff, index_in;
   logic        rvalid_ff, rvalid_in;
   logic [47:0] rmac_ff, rmac_in;
   logic [31:0] rip_ff, rip_in;

   logic                          ram_we;
   logic [arpc_pkg::IDX_W-1:0]    ram_waddr;
   logic                          ram_re;
   logic [arpc_pkg::ENTRY_W-1:0]  ram_rdata;

   logic req_fire, rsp_fire, out_free;
   logic bad_hw, bad_proto, hit_now, scan_end, decide, finish, for_us, full;

   arpc_ram #(
      .WIDTH (arpc_pkg::ENTRY_W),
      .DEPTH (arpc_pkg::TABLE_ENTRIES)
   ) u_cache (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({smac_ff, sip_ff}),
      .re    (ram_re),
      .raddr (scan_ff[arpc_pkg::IDX_W-1:0]),
      .rdata (ram_rdata)
   );

   assign req_chan.ready = (state_ff == arpc_pkg::S_IDLE);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign bad_hw = (hw_ff != arpc_pkg::HW_ETHERNET);
   assign bad_proto = (proto_ff != arpc_pkg::PROTO_IPV4);
   assign hit_now = pend_ff && (ram_rdata[31:0] == sip_ff);
   assign scan_end = (scan_ff == count_ff);
   assign decide = bad_hw || bad_proto || hit_now || scan_end;
   assign finish = (state_ff == arpc_pkg::S_SCAN) && decide && out_free;
   assign for_us = (tip_ff == local_ip_ff);
   assign full = (count_ff == arpc_pkg::CNT_W'(arpc_pkg::TABLE_ENTRIES));

   assign ram_re = (state_ff == arpc_pkg::S_SCAN) && !decide;
   assign ram_waddr = hit_now ? cmp_idx_ff : count_ff[arpc_pkg::IDX_W-1:0];
   assign ram_we = finish && !bad_hw && !bad_proto && (hit_now || (for_us && !full));

   always_comb begin
      local_ip_in = local_ip_ff;
      local_mac_in = local_mac_ff;
      if (csr_we) begin
         unique case (csr_index)
            arpc_pkg::CSR_LOCAL_IP:  local_ip_in = csr_wdata[31:0];
            arpc_pkg::CSR_LOCAL_MAC: local_mac_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      hw_in = hw_ff;
      proto_in = proto_ff;
      op_in = op_ff;
      smac_in = smac_ff;
      sip_in = sip_ff;
      tip_in = tip_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      cmp_idx_in = cmp_idx_ff;
      pend_in = pend_ff;
      unique case (state_ff)
         arpc_pkg::S_IDLE: begin
            if (req_fire) begin
               hw_in = req_chan.hw_type;
               proto_in = req_chan.proto_type;
               op_in = req_chan.arp_operation;
               smac_in = req_chan.sender_mac;
               sip_in = req_chan.sender_ip;
               tip_in = req_chan.target_ip;
               scan_in = '0;
               pend_in = 1'b0;
               state_in = arpc_pkg::S_SCAN;
            end
         end
         arpc_pkg::S_SCAN: begin
            if (!decide) begin
               cmp_idx_in = scan_ff[arpc_pkg::IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end else if (out_free) begin
               if (ram_we && !hit_now) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = arpc_pkg::S_IDLE;
            end
         end
         default: state_in = arpc_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      status_in = status_ff;
      action_in = action_ff;
      index_in = index_ff;
      rvalid_in = rvalid_ff;
      rmac_in = rmac_ff;
      rip_in = rip_ff;
      if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in = 1'b1;
         status_in = arpc_pkg::ST_REPLY;
         action_in = arpc_pkg::ACT_NONE;
         index_in = 4'd0;
         rvalid_in = 1'b0;
         rmac_in = '0;
         rip_in = '0;
         if (bad_hw) begin
            status_in = arpc_pkg::ST_BAD_HW;
         end else if (bad_proto) begin
            status_in = arpc_pkg::ST_BAD_PROTO;
         end else begin
            if (hit_now) begin
               action_in = arpc_pkg::ACT_MERGED;
               index_in = arpc_pkg::idx_to_out(cmp_idx_ff);
            end
            if (!for_us) begin
               status_in = arpc_pkg::ST_NOT_FOR_US;
            end else if (!hit_now && full) begin
               status_in = arpc_pkg::ST_TABLE_FULL;
            end else begin
               if (!hit_now) begin
                  action_in = arpc_pkg::ACT_INSERTED;
                  index_in = arpc_pkg::idx_to_out(count_ff[arpc_pkg::IDX_W-1:0]);
               end
               if (op_ff == arpc_pkg::OP_REQUEST) begin
                  status_in = arpc_pkg::ST_REPLY;
                  rvalid_in = 1'b1;
                  rmac_in = smac_ff;
                  rip_in = sip_ff;
               end else begin
                  status_in = arpc_pkg::ST_NOT_REQUEST;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= arpc_pkg::S_IDLE;
         local_ip_ff <= '0;
         local_mac_ff <= '0;
         count_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         local_ip_ff <= local_ip_in;
         local_mac_ff <= local_mac_in;
         count_ff <= count_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hw_ff <= hw_in;
      proto_ff <= proto_in;
      op_ff <= op_in;
      smac_ff <= smac_in;
      sip_ff <= sip_in;
      tip_ff <= tip_in;
      scan_ff <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      status_ff <= status_in;
      action_ff <= action_in;
      index_ff <= index_in;
      rvalid_ff <= rvalid_in;
      rmac_ff <= rmac_in;
      rip_ff <= rip_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = status_ff;
   assign rsp_chan.table_action = action_ff;
   assign rsp_chan.entry_index = index_ff;
   assign rsp_chan.reply_valid = rvalid_ff;
   assign rsp_chan.reply_target_mac = rmac_ff;
   assign rsp_chan.reply_target_ip = rip_ff;

endmodule

// ===== test/tb.sv =====
module tb;

   localparam int STALL_LIMIT = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int POOL_SIZE = 24;
   localparam int MAX_REPORTS = 40;
   localparam logic [15:0] OP_REPLY = 16'h0002;
   localparam logic [31:0] HOME_IP = 32'hC0A8_0001;
   localparam logic [31:0] PEER_A = 32'h0A00_0001;
   localparam logic [31:0] PEER_B = 32'h0A00_0002;
   localparam logic [31:0] ALL_IP = 32'hFFFF_FFFF;
   localparam logic [47:0] ALL_MAC = 48'hFFFF_FFFF_FFFF;

   typedef struct packed {
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [15:0] arp_operation;
      logic [47:0] sender_mac;
      logic [31:0] sender_ip;
      logic [31:0] target_ip;
   } packet_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [1:0]  table_action;
      logic [3:0]  entry_index;
      logic        reply_valid;
      logic [47:0] reply_target_mac;
      logic [31:0] reply_target_ip;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic       req_valid = 1'b0;
   packet_type req_pkt = '0;
   logic       rsp_ready = 1'b0;
   logic                             csr_we = 1'b0;
   logic [arpc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [arpc_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   arpc_req_if req_if ();
   arpc_rsp_if rsp_if ();

   assign req_if.valid = req_valid;
   assign req_if.hw_type = req_pkt.hw_type;
   assign req_if.proto_type = req_pkt.proto_type;
   assign req_if.arp_operation = req_pkt.arp_operation;
   assign req_if.sender_mac = req_pkt.sender_mac;
   assign req_if.sender_ip = req_pkt.sender_ip;
   assign req_if.target_ip = req_pkt.target_ip;
   assign rsp_if.ready = rsp_ready;

   arp_responder_with_cache uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #2 clock = ~clock;

   // cache image and register copies
   logic        cache_valid [arpc_pkg::TABLE_ENTRIES] = '{default: 1'b0};
   logic [31:0] cache_ip [arpc_pkg::TABLE_ENTRIES];
   logic [47:0] cache_mac [arpc_pkg::TABLE_ENTRIES];
   logic [31:0] my_ip = '0;
   logic [47:0] my_mac = '0;

   logic [31:0] ip_pool [POOL_SIZE];
   packet_type pending_packets [$];
   result_type arp_expected [$];

   int  req_idle_mode = 0;
   int  rsp_idle_mode = 0;
   bit  hold_sender = 1'b0;
   int  long_hold_req = 0;
   int  long_hold_seen = 0;
   int  req_wait = 0;
   int  rsp_wait = 0;
   int  hold_left = 0;
   int  stall_cycles = 0;
   int  packets_sent = 0;
   int  mismatches = 0;
   int  status_count [8] = '{default: 0};

   function automatic result_type predict_arp_result(packet_type p);
      result_type r;
      int         i;
      int         hit;
      int         slot;
      r = '0;
      hit = -1;
      slot = -1;
      if (p.hw_type != arpc_pkg::HW_ETHERNET) begin
         r.status = arpc_pkg::ST_BAD_HW;
      end else if (p.proto_type != arpc_pkg::PROTO_IPV4) begin
         r.status = arpc_pkg::ST_BAD_PROTO;
      end else begin
         for (i = 0; i < arpc_pkg::TABLE_ENTRIES && hit < 0; i++)
            if (cache_valid[i] && cache_ip[i] == p.sender_ip) hit = i;
         if (hit >= 0) begin
            cache_mac[hit] = p.sender_mac;
            r.table_action = arpc_pkg::ACT_MERGED;
            r.entry_index = 4'(hit);
         end
         if (p.target_ip != my_ip) begin
            r.status = arpc_pkg::ST_NOT_FOR_US;
         end else begin
            if (hit < 0) begin
               for (i = 0; i < arpc_pkg::TABLE_ENTRIES && slot < 0; i++)
                  if (!cache_valid[i]) slot = i;
               if (slot >= 0) begin
                  cache_valid[slot] = 1'b1;
                  cache_ip[slot] = p.sender_ip;
                  cache_mac[slot] = p.sender_mac;
                  r.table_action = arpc_pkg::ACT_INSERTED;
                  r.entry_index = 4'(slot);
               end
            end
            if (hit < 0 && slot < 0) begin
               r.status = arpc_pkg::ST_TABLE_FULL;
            end else if (p.arp_operation == arpc_pkg::OP_REQUEST) begin
               r.status = arpc_pkg::ST_REPLY;
               r.reply_valid = 1'b1;
               r.reply_target_mac = p.sender_mac;
               r.reply_target_ip = p.sender_ip;
            end else begin
               r.status = arpc_pkg::ST_NOT_REQUEST;
            end
         end
      end
      return r;
   endfunction

   function automatic int draw_wait(int mode);
      if (mode == 0) return 0;
      if (mode == 1) return $urandom_range(0, 18);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
   endfunction

   function automatic packet_type arp_packet(logic [15:0] hw, logic [15:0] proto,
                                             logic [15:0] op, logic [47:0] mac,
                                             logic [31:0] sip, logic [31:0] tip);
      packet_type p;
      p.hw_type = hw;
      p.proto_type = proto;
      p.arp_operation = op;
      p.sender_mac = mac;
      p.sender_ip = sip;
      p.target_ip = tip;
      return p;
   endfunction

   function automatic packet_type random_packet(int pool_pct);
      packet_type p;
      int         kind;
      int         r;
      kind = $urandom_range(0, 99);
      p.hw_type = arpc_pkg::HW_ETHERNET;
      p.proto_type = arpc_pkg::PROTO_IPV4;
      p.sender_mac = 48'({$urandom, $urandom});
      if ($urandom_range(0, 99) < pool_pct)
         p.sender_ip = ip_pool[$urandom_range(0, POOL_SIZE - 1)];
      else
         p.sender_ip = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70)
         p.target_ip = my_ip;
      else if (r < 80)
         p.target_ip = my_ip ^ (32'd1 << $urandom_range(0, 31));
      else
         p.target_ip = $urandom;
      r = $urandom_range(0, 99);
      if (r < 70)
         p.arp_operation = arpc_pkg::OP_REQUEST;
      else if (r < 85)
         p.arp_operation = OP_REPLY;
      else
         p.arp_operation = 16'($urandom);
      if (kind < 5) begin
         p.hw_type = 16'($urandom);
         if (p.hw_type == arpc_pkg::HW_ETHERNET) p.hw_type = 16'hFFFF;
         if ($urandom_range(0, 1) == 1) p.proto_type = 16'($urandom);
      end else if (kind < 10) begin
         p.proto_type = 16'($urandom);
         if (p.proto_type == arpc_pkg::PROTO_IPV4) p.proto_type = p.proto_type ^ 16'h0001;
      end
      return p;
   endfunction

   function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   task automatic check_arp_result(result_type got);
      result_type want;
      if (arp_expected.size() == 0) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected response, expected none, actual %p", $time, got);
      end else begin
         want = arp_expected.pop_front();
         compare_field("status", 64'(want.status), 64'(got.status));
         compare_field("table_action", 64'(want.table_action), 64'(got.table_action));
         compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
         compare_field("reply_valid", 64'(want.reply_valid), 64'(got.reply_valid));
         compare_field("reply_target_mac", 64'(want.reply_target_mac),
                       64'(got.reply_target_mac));
         compare_field("reply_target_ip", 64'(want.reply_target_ip),
                       64'(got.reply_target_ip));
      end
      status_count[got.status]++;
   endtask

   always @(posedge clock) begin : request_driver
      bit fired;
      fired = req_valid && req_if.ready;
      if (reset) begin
         req_valid <= 1'b0;
         req_wait = 0;
      end else begin
         if (fired) begin
            arp_expected.push_back(predict_arp_result(req_pkt));
            packets_sent++;
            req_wait = draw_wait(req_idle_mode);
         end
         if (!req_valid || fired) begin
            if (req_wait > 0) begin
               req_wait--;
               req_valid <= 1'b0;
            end else if (pending_packets.size() > 0 && !hold_sender) begin
               req_pkt <= pending_packets.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : response_monitor
      bit         fired;
      result_type got;
      fired = rsp_ready && rsp_if.valid;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
         hold_left = 0;
      end else begin
         if (fired) begin
            got.status = rsp_if.status;
            got.table_action = rsp_if.table_action;
            got.entry_index = rsp_if.entry_index;
            got.reply_valid = rsp_if.reply_valid;
            got.reply_target_mac = rsp_if.reply_target_mac;
            got.reply_target_ip = rsp_if.reply_target_ip;
            check_arp_result(got);
            rsp_wait = draw_wait(rsp_idle_mode);
         end
         if (long_hold_seen != long_hold_req) begin
            long_hold_seen = long_hold_req;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_if.ready) || (rsp_ready && rsp_if.valid)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_packets.size() != 0 || req_valid || arp_expected.size() != 0);
   endtask

   task automatic write_csr(logic [arpc_pkg::CSR_INDEX_W-1:0] idx,
                            logic [arpc_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == arpc_pkg::CSR_LOCAL_IP)
         my_ip = data[31:0];
      else
         my_mac = data;
   endtask

   task automatic run_phase(logic [31:0] ip, logic [47:0] mac, int count,
                            int req_mode, int rsp_mode, int pool_pct);
      int n;
      wait_drained();
      write_csr(arpc_pkg::CSR_LOCAL_IP, arpc_pkg::CSR_DATA_W'(ip));
      write_csr(arpc_pkg::CSR_LOCAL_MAC, mac);
      @(negedge clock);
      req_idle_mode = req_mode;
      rsp_idle_mode = rsp_mode;
      for (n = 0; n < count; n++) pending_packets.push_back(random_packet(pool_pct));
   endtask

   initial begin : stimulus
      int n;
      for (n = 0; n < POOL_SIZE; n++) ip_pool[n] = $urandom;
      ip_pool[12] = PEER_A;
      ip_pool[13] = PEER_B;
      ip_pool[14] = ALL_IP;
      ip_pool[15] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_csr(arpc_pkg::CSR_LOCAL_IP, arpc_pkg::CSR_DATA_W'(HOME_IP));
      write_csr(arpc_pkg::CSR_LOCAL_MAC, 48'h0200_5E10_2030);
      @(negedge clock);
      req_idle_mode = 1;
      rsp_idle_mode = 1;
      pending_packets.push_back(arp_packet(16'h0000, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST,
                                           48'h0000_0000_0011, PEER_A, HOME_IP));
      pending_packets.push_back(arp_packet(16'hFFFF, 16'hFFFF, arpc_pkg::OP_REQUEST,
                                           48'h0000_0000_0012, PEER_A, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, 16'h0000,
                                           arpc_pkg::OP_REQUEST,
                                           48'h0000_0000_0013, PEER_A, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST,
                                           48'h0A0B_0C0D_0E0F, PEER_A, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST,
                                           48'h1A1B_1C1D_1E1F, PEER_A, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST,
                                           48'h2A2B_2C2D_2E2F, PEER_A, PEER_B));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST,
                                           48'h3A3B_3C3D_3E3F, PEER_B, ALL_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           OP_REPLY,
                                           48'h4A4B_4C4D_4E4F, PEER_B, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           16'hFFFF, ALL_MAC, ALL_IP, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST, 48'h0, 32'h0, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST, ALL_MAC, ALL_IP, HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           16'h0000,
                                           48'h5A5B_5C5D_5E5F, 32'h0, 32'h0));
      // fill the cache to the last entry, then miss on a full table
      for (n = 0; n < 12; n++)
         pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                              arpc_pkg::OP_REQUEST,
                                              48'({$urandom, $urandom}), ip_pool[n],
                                              HOME_IP));
      pending_packets.push_back(arp_packet(arpc_pkg::HW_ETHERNET, arpc_pkg::PROTO_IPV4,
                                           arpc_pkg::OP_REQUEST,
                                           48'h6A6B_6C6D_6E6F, ip_pool[16], HOME_IP));

      run_phase(HOME_IP, 48'h0200_5E10_2031, 300, 1, 1, 85);

      run_phase(32'h0, 48'h0, 300, 0, 1, 60);
      long_hold_req = long_hold_req + 1;

      run_phase(ALL_IP, ALL_MAC, 300, 1, 0, 60);
      while (pending_packets.size() > 150) @(negedge clock);
      hold_sender = 1'b1;
      do @(negedge clock); while (req_valid || arp_expected.size() != 0);
      hold_sender = 1'b0;

      run_phase($urandom, 48'({$urandom, $urandom}), 350, 2, 2, 60);
      run_phase(HOME_IP, 48'h0200_5E10_2032, 375, 0, 0, 70);

      wait_drained();
      repeat (30) @(posedge clock);
      $display("Covered %0d packets under six register settings: %0d replies, %0d bad hw,",
               packets_sent, status_count[arpc_pkg::ST_REPLY],
               status_count[arpc_pkg::ST_BAD_HW]);
      $display("%0d bad proto, %0d not for us, %0d table full, %0d non-requests.",
               status_count[arpc_pkg::ST_BAD_PROTO], status_count[arpc_pkg::ST_NOT_FOR_US],
               status_count[arpc_pkg::ST_TABLE_FULL], status_count[arpc_pkg::ST_NOT_REQUEST]);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
src/arpc_pkg.sv
src/arpc_if.sv
src/arpc_ram.sv
src/arp_responder_with_cache.sv
test/tb.sv
